FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the timer table.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OSTT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OSTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer table assertion failed");

`endif

FILE: hw/rtl/ostt_pkg.sv
// Shared types, widths and codes of the one-shot timer table.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ostt_pkg;

	localparam int ID_W      = 31;
	localparam int DUR_W     = 32;
	localparam int TIME_W    = 48;
	localparam int ACT_W     = 2;
	localparam int KIND_W    = 3;

	localparam int DEF_TIMER_SLOTS = 16;
	localparam int MAX_FIRES       = 16;
	localparam int FIRE_CNT_W      = $clog2(MAX_FIRES + 1);

	localparam int IN_TDATA_W  = ((ID_W + DUR_W + TIME_W + 1 + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((ID_W + 7) / 8) * 8;

	localparam logic [ID_W-1:0]   ID_MAX   = '1;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_TICK   = 2'd2
	} act_t;

	typedef enum logic [KIND_W-1:0] {
		EV_ADDED     = 3'd0,
		EV_FIRED     = 3'd1,
		EV_REMOVED   = 3'd2,
		EV_NOT_FOUND = 3'd3,
		EV_FULL      = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN,
		ST_TEND,
		ST_TLAST,
		ST_MERGE
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]   ident;
		logic [TIME_W-1:0] deadline;
		logic              keep;
	} slot_rec_t;

	typedef struct packed {
		logic id_eq;
		logic id_lt;
		logic due;
	} cmp_res_t;

	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] id;
		logic            last;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ostt_mem.sv
// Slot record memory of the timer table: one write port, one registered read port.
// Depends on ostt_pkg for the record type.
`timescale 1ns / 1ps
`default_nettype none

module ostt_mem #(
	parameter int TIMER_SLOTS = ostt_pkg::DEF_TIMER_SLOTS
) (
	input  wire                                              clk,
	input  wire                                              we,
	input  wire [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] waddr,
	input  ostt_pkg::slot_rec_t                              wdata,
	input  wire [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] raddr,
	output ostt_pkg::slot_rec_t                              rdata
);

	ostt_pkg::slot_rec_t mem_q [TIMER_SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ostt_cmp.sv
// Shared compare unit of the timer table: ID match, ID order and deadline due.
// Depends on ostt_pkg for the record and result types.
`timescale 1ns / 1ps
`default_nettype none

module ostt_cmp (
	input  ostt_pkg::slot_rec_t                rec,
	input  wire [ostt_pkg::ID_W-1:0]           key_id,
	input  wire [ostt_pkg::ID_W-1:0]           best_id,
	input  wire [ostt_pkg::TIME_W-1:0]         now,
	output ostt_pkg::cmp_res_t                 res
);

	always_comb begin
		res.id_eq = (rec.ident == key_id);
		res.id_lt = (rec.ident < best_id);
		res.due   = (now >= rec.deadline);
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ostt_ctrl.sv
// Sequencer of the timer table: slot scans, slot flags, ID counter and result staging.
// Depends on ostt_pkg and instantiates ostt_cmp; reads and writes ostt_mem through ports.
`timescale 1ns / 1ps
`default_nettype none

module ostt_ctrl #(
	parameter int TIMER_SLOTS = ostt_pkg::DEF_TIMER_SLOTS
) (
	input  wire                                              clk,
	input  wire                                              arst_n,
	input  wire                                              in_valid,
	output logic                                             in_ready,
	input  wire [ostt_pkg::ACT_W-1:0]                        in_act,
	input  wire [ostt_pkg::ID_W-1:0]                         in_id,
	input  wire [ostt_pkg::DUR_W-1:0]                        in_dur,
	input  wire [ostt_pkg::TIME_W-1:0]                       in_now,
	input  wire                                              in_keep,
	input  wire                                              paused,
	output logic                                             res_valid,
	input  wire                                              res_ready,
	output ostt_pkg::res_t                                   res,
	output logic                                             mem_we,
	output logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] mem_waddr,
	output ostt_pkg::slot_rec_t                              mem_wdata,
	output logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] mem_raddr,
	input  ostt_pkg::slot_rec_t                              mem_rdata
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);
	localparam logic [ostt_pkg::FIRE_CNT_W-1:0] FIRE_LIMIT =
		ostt_pkg::FIRE_CNT_W'(ostt_pkg::MAX_FIRES - 1);

	ostt_pkg::state_t state_q, state_d;

	logic [ostt_pkg::ACT_W-1:0]  op_q;
	logic [ostt_pkg::ID_W-1:0]   id_q;
	logic [ostt_pkg::TIME_W-1:0] dl_q;
	logic [ostt_pkg::TIME_W-1:0] now_q;
	logic                        keep_q;
	logic [ostt_pkg::ID_W-1:0]   cnt_q;
	logic [ostt_pkg::ID_W-1:0]   next_cnt_q;

	logic [IDX_W-1:0] scan_idx_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic             hit_pend_q, hit_act_q, free_q, best_q;
	logic [IDX_W-1:0] hit_pend_idx_q, hit_act_idx_q, free_idx_q, best_idx_q;
	logic [ostt_pkg::ID_W-1:0] best_id_q;

	logic                            held_q;
	logic [ostt_pkg::ID_W-1:0]       held_id_q;
	logic [ostt_pkg::FIRE_CNT_W-1:0] fires_q;

	logic             used_q    [TIMER_SLOTS];
	logic             pending_q [TIMER_SLOTS];
	logic             clash_q   [TIMER_SLOTS];
	logic [IDX_W-1:0] clash_idx_q [TIMER_SLOTS];

	// Sequencer strobes.
	logic             accept, scan_start, held_load, held_clr;
	logic             set_en, free_en, merge_en, cnt_en;
	logic [IDX_W-1:0] set_idx, free_idx;

	// Values formed from an add request at the input.
	logic [ostt_pkg::ID_W-1:0]   add_id, add_next_cnt;
	logic [ostt_pkg::TIME_W:0]   dl_sum;
	logic [ostt_pkg::TIME_W-1:0] dl_sat;

	ostt_pkg::cmp_res_t cmp_res;
	logic beat_used, beat_pend, beat_elig;

	ostt_cmp u_cmp (
		.rec     (mem_rdata),
		.key_id  (id_q),
		.best_id (best_id_q),
		.now     (now_q),
		.res     (cmp_res)
	);

	assign mem_raddr = scan_idx_q;

	always_comb begin
		if (in_id == '0) begin
			add_id       = (cnt_q == ostt_pkg::ID_MAX) ? ostt_pkg::ID_MAX : cnt_q + 1'b1;
			add_next_cnt = add_id;
		end else begin
			add_id = in_id;
			if (in_id > cnt_q) begin
				add_next_cnt = (in_id == ostt_pkg::ID_MAX) ? ostt_pkg::ID_MAX : in_id + 1'b1;
			end else begin
				add_next_cnt = cnt_q;
			end
		end
		dl_sum = {1'b0, in_now} + (ostt_pkg::TIME_W + 1)'(in_dur);
		dl_sat = dl_sum[ostt_pkg::TIME_W] ? ostt_pkg::TIME_MAX : dl_sum[ostt_pkg::TIME_W-1:0];
	end

	always_comb begin
		beat_used = used_q[rd_idx_s1];
		beat_pend = pending_q[rd_idx_s1];
		beat_elig = beat_used && !beat_pend && (!paused || mem_rdata.keep) && cmp_res.due &&
			(!best_q || cmp_res.id_lt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ostt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		accept    = 1'b0;
		scan_start = 1'b0;
		held_load = 1'b0;
		held_clr  = 1'b0;
		set_en    = 1'b0;
		set_idx   = free_idx_q;
		free_en   = 1'b0;
		free_idx  = best_idx_q;
		merge_en  = 1'b0;
		cnt_en    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = free_idx_q;
		mem_wdata.ident    = id_q;
		mem_wdata.deadline = dl_q;
		mem_wdata.keep     = keep_q;
		res_valid = 1'b0;
		res.kind  = ostt_pkg::EV_FIRED;
		res.id    = held_id_q;
		res.last  = 1'b0;

		case (state_q)
			ostt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept = 1'b1;
					if (in_act == ostt_pkg::ACT_ADD || in_act == ostt_pkg::ACT_REMOVE ||
						in_act == ostt_pkg::ACT_TICK) begin
						scan_start = 1'b1;
						state_d    = ostt_pkg::ST_SCAN;
					end
				end
			end
			ostt_pkg::ST_SCAN: begin
				if (scan_idx_q == LAST_IDX) begin
					state_d = ostt_pkg::ST_DRAIN;
				end
			end
			ostt_pkg::ST_DRAIN: begin
				state_d = (op_q == ostt_pkg::ACT_TICK) ? ostt_pkg::ST_TEND : ostt_pkg::ST_FIN;
			end
			ostt_pkg::ST_FIN: begin
				res.id   = id_q;
				res.last = 1'b1;
				if (op_q == ostt_pkg::ACT_ADD) begin
					res.kind = (hit_pend_q || free_q) ? ostt_pkg::EV_ADDED : ostt_pkg::EV_FULL;
				end else begin
					res.kind = (hit_act_q || hit_pend_q) ? ostt_pkg::EV_REMOVED :
						ostt_pkg::EV_NOT_FOUND;
				end
				if (res_ready) begin
					res_valid = 1'b1;
					state_d   = ostt_pkg::ST_IDLE;
					if (op_q == ostt_pkg::ACT_ADD) begin
						// A pending timer with the same ID is overwritten in place.
						set_en    = hit_pend_q || free_q;
						set_idx   = hit_pend_q ? hit_pend_idx_q : free_idx_q;
						mem_we    = set_en;
						mem_waddr = set_idx;
						cnt_en    = set_en;
					end else begin
						free_en  = hit_act_q || hit_pend_q;
						free_idx = hit_act_q ? hit_act_idx_q : hit_pend_idx_q;
					end
				end
			end
			ostt_pkg::ST_TEND: begin
				if (best_q) begin
					// The previous fire goes out only now that another one follows it.
					if (!held_q || res_ready) begin
						res_valid = held_q;
						free_en   = 1'b1;
						held_load = 1'b1;
						if (fires_q == FIRE_LIMIT) begin
							state_d = ostt_pkg::ST_TLAST;
						end else begin
							scan_start = 1'b1;
							state_d    = ostt_pkg::ST_SCAN;
						end
					end
				end else begin
					state_d = held_q ? ostt_pkg::ST_TLAST : ostt_pkg::ST_MERGE;
				end
			end
			ostt_pkg::ST_TLAST: begin
				res.last = 1'b1;
				if (res_ready) begin
					res_valid = 1'b1;
					held_clr  = 1'b1;
					state_d   = ostt_pkg::ST_MERGE;
				end
			end
			ostt_pkg::ST_MERGE: begin
				merge_en = 1'b1;
				state_d  = ostt_pkg::ST_IDLE;
			end
			default: begin
				state_d = ostt_pkg::ST_IDLE;
			end
		endcase
	end

	// Request fields and the scan pipeline.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= in_act;
			id_q       <= (in_act == ostt_pkg::ACT_ADD) ? add_id : in_id;
			next_cnt_q <= add_next_cnt;
			dl_q       <= dl_sat;
			now_q      <= in_now;
			keep_q     <= in_keep;
		end
		rd_idx_s1 <= scan_idx_q;
		if (beat_elig && rd_vld_s1) begin
			best_id_q  <= mem_rdata.ident;
			best_idx_q <= rd_idx_s1;
		end
		if (rd_vld_s1 && beat_used && beat_pend && cmp_res.id_eq && !hit_pend_q) begin
			hit_pend_idx_q <= rd_idx_s1;
		end
		if (rd_vld_s1 && beat_used && !beat_pend && cmp_res.id_eq && !hit_act_q) begin
			hit_act_idx_q <= rd_idx_s1;
		end
		if (rd_vld_s1 && !beat_used && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (held_load) begin
			held_id_q <= best_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= ostt_pkg::ID_W'(1);
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			hit_pend_q <= 1'b0;
			hit_act_q  <= 1'b0;
			free_q     <= 1'b0;
			best_q     <= 1'b0;
			held_q     <= 1'b0;
			fires_q    <= '0;
		end else begin
			if (cnt_en) begin
				cnt_q <= next_cnt_q;
			end
			rd_vld_s1 <= (state_q == ostt_pkg::ST_SCAN);
			if (scan_start) begin
				scan_idx_q <= '0;
				hit_pend_q <= 1'b0;
				hit_act_q  <= 1'b0;
				free_q     <= 1'b0;
				best_q     <= 1'b0;
			end else begin
				if (state_q == ostt_pkg::ST_SCAN) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (rd_vld_s1) begin
					if (beat_used && beat_pend && cmp_res.id_eq) begin
						hit_pend_q <= 1'b1;
					end
					if (beat_used && !beat_pend && cmp_res.id_eq) begin
						hit_act_q <= 1'b1;
					end
					if (!beat_used) begin
						free_q <= 1'b1;
					end
					if (beat_elig) begin
						best_q <= 1'b1;
					end
				end
			end
			if (accept && in_act == ostt_pkg::ACT_TICK) begin
				fires_q <= '0;
				held_q  <= 1'b0;
			end else if (held_load) begin
				fires_q <= fires_q + 1'b1;
				held_q  <= 1'b1;
			end else if (held_clr) begin
				held_q <= 1'b0;
			end
		end
	end

	// Slot flags. A pending slot remembers which active slot holds its ID; freeing that
	// active slot lifts the clash, so the merge needs no second scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				used_q[i]    <= 1'b0;
				pending_q[i] <= 1'b0;
				clash_q[i]   <= 1'b0;
			end
		end else begin
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				if (merge_en) begin
					if (used_q[i] && pending_q[i] && clash_q[i]) begin
						used_q[i] <= 1'b0;
					end
					pending_q[i] <= 1'b0;
					clash_q[i]   <= 1'b0;
				end else begin
					if (free_en && clash_idx_q[i] == free_idx) begin
						clash_q[i] <= 1'b0;
					end
					if (free_en && free_idx == IDX_W'(i)) begin
						used_q[i]    <= 1'b0;
						pending_q[i] <= 1'b0;
						clash_q[i]   <= 1'b0;
					end
					if (set_en && set_idx == IDX_W'(i)) begin
						used_q[i]    <= 1'b1;
						pending_q[i] <= 1'b1;
						clash_q[i]   <= hit_act_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			if (set_en && set_idx == IDX_W'(i)) begin
				clash_idx_q[i] <= hit_act_idx_q;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/one_shot_timer_table_top.sv
// Top level of the one-shot timer table: stream ports, pause register, output register.
// Depends on ostt_pkg and instantiates ostt_ctrl and ostt_mem.
// Add and remove make one scan of the slot memory, one record per cycle through a single
// compare unit. A tick fires at most 16 timers, one full scan per fired timer in ascending
// ID order; output stalls hold the tick up.
// One item is in work at a time; the input is not ready until the item is done.
// Reset clears all slot flags, the ID counter (to one) and the pause bit at once.
`timescale 1ns / 1ps
`default_nettype none

module one_shot_timer_table_top #(
	parameter int TIMER_SLOTS = ostt_pkg::DEF_TIMER_SLOTS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	// timer_id [30:0], duration_ms [62:31], now_ms [110:63], keep_when_paused [111]
	input  wire [ostt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// action [1:0]
	input  wire [ostt_pkg::ACT_W-1:0]          s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	// result_id [30:0], zero [31]
	output logic [ostt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// event_kind [2:0]
	output logic [ostt_pkg::KIND_W-1:0]        m_axis_tuser,
	output logic                               m_axis_tlast,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire                                cfg_data
);

	localparam int IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int DUR_LO = ostt_pkg::ID_W;
	localparam int NOW_LO = DUR_LO + ostt_pkg::DUR_W;
	localparam int KEEP_B = NOW_LO + ostt_pkg::TIME_W;

	logic           paused_q;
	logic           out_valid_q;
	ostt_pkg::res_t out_beat_q;

	logic           res_valid, res_ready;
	ostt_pkg::res_t res;

	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr, mem_raddr;
	ostt_pkg::slot_rec_t mem_wdata, mem_rdata;

	ostt_ctrl #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_act    (s_axis_tuser),
		.in_id     (s_axis_tdata[ostt_pkg::ID_W-1:0]),
		.in_dur    (s_axis_tdata[NOW_LO-1:DUR_LO]),
		.in_now    (s_axis_tdata[KEEP_B-1:NOW_LO]),
		.in_keep   (s_axis_tdata[KEEP_B]),
		.paused    (paused_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ostt_mem #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q <= 1'b0;
		end else if (cfg_valid) begin
			paused_q <= cfg_data;
		end
	end

	// The output register frees up in the same cycle its beat is taken.
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_beat_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = ostt_pkg::OUT_TDATA_W'(out_beat_q.id);
	assign m_axis_tuser  = out_beat_q.kind;
	assign m_axis_tlast  = out_beat_q.last;

endmodule

`default_nettype wire

FILE: hw/rtl/ostt_chk.sv
// Port-level checker of the timer table, bound to the top level.
// Depends on ostt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ostt_chk (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_axis_tvalid,
	input wire                               s_axis_tready,
	input wire [ostt_pkg::ACT_W-1:0]         s_axis_tuser,
	input wire                               m_axis_tvalid,
	input wire                               m_axis_tready,
	input wire [ostt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input wire [ostt_pkg::KIND_W-1:0]        m_axis_tuser,
	input wire                               m_axis_tlast
);

	// Any real request keeps the block busy for at least the following cycle.
	`OSTT_ASSERT_NEXT(busy_after_request, s_axis_tvalid && s_axis_tready && (s_axis_tuser == ostt_pkg::ACT_ADD || s_axis_tuser == ostt_pkg::ACT_REMOVE || s_axis_tuser == ostt_pkg::ACT_TICK), !s_axis_tready)

	`OSTT_ASSERT_NEXT(out_beat_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

	// Only fire beats come in runs; every other result stands alone.
	`OSTT_ASSERT_SAME(single_beat_results, m_axis_tvalid && m_axis_tuser != ostt_pkg::EV_FIRED, m_axis_tlast)

	// An allocated or requested ID is never zero.
	`OSTT_ASSERT_SAME(added_id_nonzero, m_axis_tvalid && m_axis_tuser == ostt_pkg::EV_ADDED, m_axis_tdata[ostt_pkg::ID_W-1:0] != '0)

endmodule

bind one_shot_timer_table_top ostt_chk u_ostt_chk (.*);

`default_nettype wire
